// ----- hdl/scoc_pkg.sv -----
// ----------------------------------------------------------------------------
// scoc_pkg
// Shared types and constants for the signed circle-of-confusion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package scoc_pkg;

  localparam int unsigned DW       = 114;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DIV_STEPS = 16;
  localparam logic [31:0] NEAR_PUSH = 32'd7;

  typedef enum logic [2:0] {
    CFG_FOCUS  = 3'd0,
    CFG_FOCAL  = 3'd1,
    CFG_FNUM   = 3'd2,
    CFG_SENSOR = 3'd3,
    CFG_MAX    = 3'd4,
    CFG_TOL    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] focus;
    logic [31:0] focal;
    logic [15:0] fnum;
    logic [31:0] sensor;
    logic [15:0] maxb;
    logic [15:0] tol;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [DW-1:0]     rem;
    logic [DW-1:0]     den;
    logic [FRAC_W-1:0] frac;
    logic              sat;
    logic              neg;
  } div_t;

endpackage
`default_nettype wire

// ----- hdl/scoc_if.sv -----
// ----------------------------------------------------------------------------
// scoc_if
// Stream channels: depth in, blur result out.
// ----------------------------------------------------------------------------
`default_nettype none
interface scoc_depth_if;
  logic        valid;
  logic        ready;
  logic [31:0] depth;
  modport source (output valid, output depth, input ready);
  modport sink   (input valid, input depth, output ready);
endinterface

interface scoc_blur_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] blur;
  logic               in_focus;
  modport source (output valid, output blur, output in_focus, input ready);
  modport sink   (input valid, input blur, input in_focus, output ready);
endinterface
`default_nettype wire

// ----- hdl/signed_circle_of_confusion.sv -----
// ----------------------------------------------------------------------------
// signed_circle_of_confusion
// Thin-lens signed blur size per pixel depth.
//
// Channels: pix (sink) carries one Q16.16 depth per beat; coc (source)
// returns one signed Q8.8 blur and an in-focus flag per beat, in order.
// Lens registers are written through cfg_we/cfg_index/cfg_data; the user is
// to write them only while idle, as the block does not enforce it. Unknown
// indexes are ignored. An accepted beat passes through five stages of clamp,
// products and saturation test, sixteen restoring division stages (one
// quotient bit each), a scaling multiply and the output register on its way
// to coc. The pipeline takes one beat per cycle while coc does not stall.
// The whole pipeline advances when the output register is empty or taken;
// while coc stalls with a result waiting, pix.ready is low and every stage
// holds. Reset (synchronous) empties the pipeline and loads the default
// lens registers.
// ----------------------------------------------------------------------------
`default_nettype none
module signed_circle_of_confusion
  import scoc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  scoc_depth_if.sink       pix,
  scoc_blur_if.source      coc,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t cfg;
  logic en;
  div_t stg [0:DIV_STEPS];

  assign en        = !coc.valid || coc.ready;
  assign pix.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focus  <= 32'd655360;
      cfg.focal  <= 32'd3277;
      cfg.fnum   <= 16'd717;
      cfg.sensor <= 32'd2359;
      cfg.maxb   <= 16'd4096;
      cfg.tol    <= 16'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOCUS:  cfg.focus  <= cfg_data;
        CFG_FOCAL:  cfg.focal  <= cfg_data;
        CFG_FNUM:   cfg.fnum   <= cfg_data[15:0];
        CFG_SENSOR: cfg.sensor <= cfg_data;
        CFG_MAX:    cfg.maxb   <= cfg_data[15:0];
        CFG_TOL:    cfg.tol    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  scoc_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(pix.valid), .depth(pix.depth),
    .cfg(cfg), .out(stg[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    scoc_div_step u_step (
      .clk(clk), .rst(rst), .en(en), .in(stg[i]), .out(stg[i+1])
    );
  end

  scoc_back u_back (
    .clk(clk), .rst(rst), .en(en), .in(stg[DIV_STEPS]), .cfg(cfg),
    .valid(coc.valid), .blur(coc.blur), .in_focus(coc.in_focus)
  );

endmodule
`default_nettype wire

// ----- hdl/scoc_front.sv -----
// ----------------------------------------------------------------------------
// scoc_front
// Near-lens clamp, products of numerator and denominator, saturation test.
// Five register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module scoc_front
  import scoc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] depth,
  input  wire cfg_t        cfg,
  output div_t             out
);

  logic [32:0] d_c, s_c;
  logic        v1, z1, neg1;
  logic [32:0] d1, diff1;
  logic [31:0] sf1;
  logic        v2, z2, neg2;
  logic [63:0] ff2;
  logic [64:0] dsf2;
  logic [47:0] nw2;
  logic [32:0] diff2;
  logic        v3, z3, neg3;
  logic [64:0] pn_lo3, pn_hi3;
  logic [55:0] a0_3, a1_3;
  logic [56:0] a2_3, a3_3;
  logic        v4, neg4;
  logic [DW-1:0] num4, den4;
  logic [15:0] n_c;

  always_comb begin
    d_c = (depth <= cfg.focal) ? {1'b0, cfg.focal} + {1'b0, NEAR_PUSH} : {1'b0, depth};
    s_c = (cfg.focus <= cfg.focal) ? {1'b0, cfg.focal} + {1'b0, NEAR_PUSH}
                                   : {1'b0, cfg.focus};
    n_c = (z1) ? 16'd1 : cfg.fnum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; out.valid <= v4;
    end
    if (en) begin
      out.rem  <= num4;
      out.den  <= den4;
      out.frac <= '0;
      out.sat  <= (num4 >= den4);
      out.neg  <= neg4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1    <= d_c;
      diff1 <= (d_c >= s_c) ? d_c - s_c : s_c - d_c;
      sf1   <= 32'(s_c - {1'b0, cfg.focal});
      z1    <= (cfg.fnum == 16'd0);
      neg1  <= (depth < cfg.focus);

      ff2   <= 64'(cfg.focal) * 64'(cfg.focal);
      dsf2  <= 65'(d1) * 65'(sf1);
      nw2   <= 48'(n_c) * 48'(cfg.sensor);
      diff2 <= diff1;
      z2    <= z1;
      neg2  <= neg1;

      pn_lo3 <= 65'(ff2[31:0]) * 65'(diff2);
      pn_hi3 <= 65'(ff2[63:32]) * 65'(diff2);
      a0_3   <= 56'(dsf2[31:0]) * 56'(nw2[23:0]);
      a1_3   <= 56'(dsf2[31:0]) * 56'(nw2[47:24]);
      a2_3   <= 57'(dsf2[64:32]) * 57'(nw2[23:0]);
      a3_3   <= 57'(dsf2[64:32]) * 57'(nw2[47:24]);
      z3     <= z2;
      neg3   <= neg2;

      num4 <= ((DW'(pn_hi3) << 32) + DW'(pn_lo3)) << (z3 ? 0 : 8);
      den4 <= DW'(a0_3) + (DW'(a1_3) << 24) + (DW'(a2_3) << 32) + (DW'(a3_3) << 56);
      neg4 <= neg3;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/scoc_div_step.sv -----
// ----------------------------------------------------------------------------
// scoc_div_step
// One restoring division step: one quotient bit of the blur ratio.
// ----------------------------------------------------------------------------
`default_nettype none
module scoc_div_step
  import scoc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire div_t in,
  output div_t      out
);

  logic [DW-1:0] r2;
  logic          take;

  always_comb begin
    r2   = in.rem << 1;
    take = (r2 >= in.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= in.valid;
    end
    if (en) begin
      out.den <= in.den;
      out.sat <= in.sat;
      out.neg <= in.neg;
      if (in.sat) begin
        out.rem  <= in.rem;
        out.frac <= in.frac;
      end else begin
        out.rem  <= take ? r2 - in.den : r2;
        out.frac <= {in.frac[FRAC_W-2:0], take};
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/scoc_back.sv -----
// ----------------------------------------------------------------------------
// scoc_back
// Scales the ratio to texels, applies sign and focus test; output register.
// ----------------------------------------------------------------------------
`default_nettype none
module scoc_back
  import scoc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire div_t        in,
  input  wire cfg_t        cfg,
  output logic             valid,
  output logic signed [16:0] blur,
  output logic             in_focus
);

  logic [31:0] prod;
  logic        va, nega;
  logic [15:0] maga;

  assign prod = 32'(in.frac) * 32'(cfg.maxb);

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      va    <= in.valid;
      valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      maga     <= in.sat ? cfg.maxb : prod[31:16];
      nega     <= in.neg;
      blur     <= nega ? -$signed({1'b0, maga}) : $signed({1'b0, maga});
      in_focus <= (maga <= cfg.tol);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/scoc_checker.sv -----
// ----------------------------------------------------------------------------
// scoc_checker
// Port-level checks on the circle-of-confusion block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
module scoc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [16:0] blur,
  input wire logic               in_focus
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output flow");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(blur))
    else $error("stalled result changed");

  a_zero_focus: assert property (@(posedge clk) disable iff (rst)
    out_valid && blur == 17'sd0 |-> in_focus)
    else $error("zero blur not flagged in focus");

endmodule

bind signed_circle_of_confusion scoc_checker u_scoc_checker (
  .clk(clk), .rst(rst), .in_ready(pix.ready), .out_valid(coc.valid),
  .out_ready(coc.ready), .blur(coc.blur), .in_focus(coc.in_focus)
);
`default_nettype wire
